FILE: sv/vwi_pkg.sv
// Shared constants for the vertex weld indexer.
package vwi_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_VERTS_DEF  = 1024;
    localparam int COORD_BITS_DEF = 32;

    // Port field widths.
    localparam int COORD_W   = 32;
    localparam int TOL_W     = 16;
    localparam int IDX_OUT_W = 10;
    localparam int S_DATA_W  = 3 * COORD_W;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 16;
    localparam int M_PAD_W   = M_DATA_W - IDX_OUT_W - 2;

    // Bit positions in s_tuser.
    localparam int USER_KIND_BIT  = 0;
    localparam int USER_START_BIT = 1;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

endpackage

FILE: sv/vwi_match.sv
// Per-axis tolerance compare of a vertex against one stored vertex.
module vwi_match #(
    parameter int CW = vwi_pkg::COORD_BITS_DEF
) (
    input  logic [CW-1:0]              vx,
    input  logic [CW-1:0]              vy,
    input  logic [CW-1:0]              vz,
    input  logic [CW-1:0]              sx,
    input  logic [CW-1:0]              sy,
    input  logic [CW-1:0]              sz,
    input  logic [vwi_pkg::TOL_W-1:0]  tol,
    output logic                       hit
);

    localparam int DW = (CW + 1 > vwi_pkg::TOL_W) ? CW + 1 : vwi_pkg::TOL_W;

    // The difference of two CW-bit signed values always fits in CW+1 bits.
    function automatic logic axis_close(input logic [CW-1:0] a,
                                        input logic [CW-1:0] b,
                                        input logic [vwi_pkg::TOL_W-1:0] t);
        logic [CW:0] d;
        logic [CW:0] mag;
        d   = {a[CW-1], a} - {b[CW-1], b};
        mag = d[CW] ? (~d + 1'b1) : d;
        return DW'(mag) < DW'(t);
    endfunction

    assign hit = axis_close(vx, sx, tol) && axis_close(vy, sy, tol) &&
                 axis_close(vz, sz, tol);

endmodule

FILE: sv/vertex_weld_indexer_top.sv
// Vertex weld indexer: assigns shared vertex indices by tolerance search.
//
//  channel | direction | signals                              | meaning
//  s       | in        | s_tvalid s_tready s_tdata s_tuser s_tlast | face vertices
//  m       | out       | m_tvalid m_tready m_tdata m_tlast    | vertex indices
//  cfg     | in        | cfg_valid cfg_ready cfg_data         | match tolerance
//
// A first-face vertex goes from transfer through the scan and done states to the
// output register. A searched vertex scans the store, read one entry per cycle,
// newest first, into a single compare unit, and the scan stops at the first hit.
// s_tready is high only while no vertex is being worked on; a finished result
// waits in the output register, and a new vertex is taken while it waits.
// Reset empties the store and sets the tolerance to 1; no clearing pass is needed.
module vertex_weld_indexer_top #(
    parameter int MAX_VERTS  = vwi_pkg::MAX_VERTS_DEF,
    parameter int COORD_BITS = vwi_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] coord_x, [63:32] coord_y, [95:64] coord_z
    input  logic [vwi_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] kind, [1] start_mesh
    input  logic [vwi_pkg::S_USER_W-1:0]  s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [9:0] vertex_index, [10] is_new, [11] overflow, [15:12] zero
    output logic [vwi_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vwi_pkg::TOL_W-1:0]     cfg_data
);

    localparam int CW   = (COORD_BITS < vwi_pkg::COORD_W) ? COORD_BITS : vwi_pkg::COORD_W;
    localparam int IW   = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CNTW = $clog2(MAX_VERTS + 1);
    localparam int OW   = vwi_pkg::IDX_OUT_W;
    localparam int XLO  = 0;
    localparam int YLO  = vwi_pkg::COORD_W;
    localparam int ZLO  = 2 * vwi_pkg::COORD_W;
    localparam logic [CNTW-1:0] CNT_MAX  = CNTW'(MAX_VERTS);
    localparam logic [IW-1:0]   IDX_LAST = IW'(MAX_VERTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [vwi_pkg::TOL_W-1:0]  tol_reg, tol_next;
    logic [CNTW-1:0]            stored_count_reg, stored_count_next;
    logic [CNTW-1:0]            left_reg, left_next;
    logic                       rd_valid_reg, rd_valid_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    logic [IW-1:0]              addr_reg, addr_next;
    logic [IW-1:0]              rd_idx_reg, rd_idx_next;
    logic [CW-1:0]              vx_reg, vx_next;
    logic [CW-1:0]              vy_reg, vy_next;
    logic [CW-1:0]              vz_reg, vz_next;
    logic                       face_end_reg, face_end_next;
    logic [IW-1:0]              res_index_reg, res_index_next;
    logic                       res_new_reg, res_new_next;
    logic                       res_over_reg, res_over_next;
    logic [OW-1:0]              m_index_reg, m_index_next;
    logic                       m_new_reg, m_new_next;
    logic                       m_over_reg, m_over_next;
    logic                       m_last_reg, m_last_next;

    logic [CW-1:0]              mem_x [MAX_VERTS];
    logic [CW-1:0]              mem_y [MAX_VERTS];
    logic [CW-1:0]              mem_z [MAX_VERTS];
    logic [CW-1:0]              rd_x_reg, rd_y_reg, rd_z_reg;

    logic                       in_xfer;
    logic                       match_hit;
    logic                       hit;
    logic                       miss;
    logic                       issue;
    logic                       mem_wr;
    logic [CNTW-1:0]            count_eff;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {{vwi_pkg::M_PAD_W{1'b0}}, m_over_reg, m_new_reg, m_index_reg};

    assign in_xfer   = s_tvalid && s_tready;
    assign count_eff = s_tuser[vwi_pkg::USER_START_BIT] ? '0 : stored_count_reg;

    vwi_match #(
        .CW (CW)
    ) u_match (
        .vx  (vx_reg),
        .vy  (vy_reg),
        .vz  (vz_reg),
        .sx  (rd_x_reg),
        .sy  (rd_y_reg),
        .sz  (rd_z_reg),
        .tol (tol_reg),
        .hit (match_hit)
    );

    // Reads are registered; a hit stops the scan and drops the next read.
    assign hit    = (state_reg == ST_SCAN) && rd_valid_reg && match_hit;
    assign miss   = (state_reg == ST_SCAN) && !hit && (left_reg == '0);
    assign issue  = (state_reg == ST_SCAN) && !hit && (left_reg != '0);
    assign mem_wr = miss && (stored_count_reg < CNT_MAX);

    always_comb
    begin
        state_next        = state_reg;
        tol_next          = cfg_valid ? cfg_data : tol_reg;
        stored_count_next = stored_count_reg;
        left_next         = left_reg;
        rd_valid_next     = 1'b0;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        addr_next         = addr_reg;
        rd_idx_next       = rd_idx_reg;
        vx_next           = vx_reg;
        vy_next           = vy_reg;
        vz_next           = vz_reg;
        face_end_next     = face_end_reg;
        res_index_next    = res_index_reg;
        res_new_next      = res_new_reg;
        res_over_next     = res_over_reg;
        m_index_next      = m_index_reg;
        m_new_next        = m_new_reg;
        m_over_next       = m_over_reg;
        m_last_next       = m_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next        = ST_SCAN;
                    stored_count_next = count_eff;
                    left_next         = s_tuser[vwi_pkg::USER_KIND_BIT] ? count_eff : '0;
                    addr_next         = IW'(count_eff - 1'b1);
                    vx_next           = s_tdata[XLO +: CW];
                    vy_next           = s_tdata[YLO +: CW];
                    vz_next           = s_tdata[ZLO +: CW];
                    face_end_next     = s_tlast;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = addr_reg;
                    addr_next     = addr_reg - 1'b1;
                    left_next     = left_reg - 1'b1;
                end
                if (hit)
                begin
                    res_index_next = rd_idx_reg;
                    res_new_next   = 1'b0;
                    res_over_next  = 1'b0;
                    state_next     = ST_DONE;
                end
                else if (miss)
                begin
                    if (stored_count_reg < CNT_MAX)
                    begin
                        res_index_next    = stored_count_reg[IW-1:0];
                        res_new_next      = 1'b1;
                        res_over_next     = 1'b0;
                        stored_count_next = stored_count_reg + 1'b1;
                    end
                    else
                    begin
                        res_index_next = IDX_LAST;
                        res_new_next   = 1'b0;
                        res_over_next  = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_index_next  = OW'(res_index_reg);
                    m_new_next    = res_new_reg;
                    m_over_next   = res_over_reg;
                    m_last_next   = face_end_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tol_reg          <= vwi_pkg::TOL_RESET;
            stored_count_reg <= '0;
            left_reg         <= '0;
            rd_valid_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tol_reg          <= tol_next;
            stored_count_reg <= stored_count_next;
            left_reg         <= left_next;
            rd_valid_reg     <= rd_valid_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        rd_idx_reg    <= rd_idx_next;
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        vz_reg        <= vz_next;
        face_end_reg  <= face_end_next;
        res_index_reg <= res_index_next;
        res_new_reg   <= res_new_next;
        res_over_reg  <= res_over_next;
        m_index_reg   <= m_index_next;
        m_new_reg     <= m_new_next;
        m_over_reg    <= m_over_next;
        m_last_reg    <= m_last_next;
    end

    // Vertex store: one write port at the fill count, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem_x[stored_count_reg[IW-1:0]] <= vx_reg;
            mem_y[stored_count_reg[IW-1:0]] <= vy_reg;
            mem_z[stored_count_reg[IW-1:0]] <= vz_reg;
        end
        if (issue)
        begin
            rd_x_reg <= mem_x[addr_reg];
            rd_y_reg <= mem_y[addr_reg];
            rd_z_reg <= mem_z[addr_reg];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= CNT_MAX)
        else $error("stored vertex count exceeds the store depth");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |=> stored_count_reg == $past(stored_count_reg) + 1'b1)
        else $error("store write did not advance the fill count");

    a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && rd_valid_reg) |-> CNTW'(rd_idx_reg) < stored_count_reg)
        else $error("scan read an entry beyond the fill count");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_new_reg && m_over_reg))
        else $error("result marked both appended and overflowed");

    a_ready_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("vertex taken while the previous one is still being searched");

endmodule
